@@ src/pdlp_pkg.sv @@
package pdlp_pkg;

  localparam int CntBits   = 20;
  localparam int KindBits  = 4;
  localparam int VtxBits   = 16;
  localparam int OffBits   = 23;
  localparam int AddrBits  = 19;
  localparam int ShapeBits = 2;
  localparam int TdataBits = 96;

  // result kinds
  localparam logic [KindBits-1:0] KindVtxGroup = 4'd0;
  localparam logic [KindBits-1:0] KindVtx      = 4'd1;
  localparam logic [KindBits-1:0] KindTri      = 4'd2;
  localparam logic [KindBits-1:0] KindEnd      = 4'd3;
  localparam logic [KindBits-1:0] KindCall     = 4'd4;
  localparam logic [KindBits-1:0] KindTex      = 4'd5;
  localparam logic [KindBits-1:0] KindTexOn    = 4'd6;
  localparam logic [KindBits-1:0] KindTexOff   = 4'd7;
  localparam logic [KindBits-1:0] KindTerm     = 4'd8;
  localparam logic [KindBits-1:0] KindBad      = 4'd9;

  // opcodes
  localparam logic [7:0] OpTerm      = 8'hFF;
  localparam logic [7:0] OpGroupLo   = 8'h33;
  localparam logic [7:0] OpGroupHi   = 8'h52;
  localparam logic [7:0] OpVtx       = 8'h28;
  localparam logic [7:0] OpTri       = 8'h29;
  localparam logic [7:0] OpQuad      = 8'h58;
  localparam logic [7:0] OpEnd       = 8'h2A;
  localparam logic [7:0] OpCall      = 8'h2B;
  localparam logic [7:0] OpTexOn     = 8'h26;
  localparam logic [7:0] OpTexOff    = 8'h27;
  localparam logic [7:0] OpTexLo     = 8'h20;
  localparam logic [7:0] OpTexHi     = 8'h25;
  localparam logic [7:0] OpWideHi    = 8'h14;
  localparam logic [7:0] OpShortHi   = 8'h19;
  localparam logic [7:0] OpPair3Lo   = 8'h1A;
  localparam logic [7:0] OpPair3Hi   = 8'h1F;
  localparam logic [7:0] OpPair3Alt  = 8'h2C;
  localparam logic [7:0] OpNopLo     = 8'h2D;
  localparam logic [7:0] OpNopHi     = 8'h2F;
  localparam logic [7:0] OpSkip3     = 8'h30;
  localparam logic [7:0] OpNop2Lo    = 8'h53;
  localparam logic [7:0] OpNop2Hi    = 8'h57;

  typedef struct packed {
    logic       known;
    logic [2:0] len;   // payload bytes after the opcode
    logic [2:0] adv;   // slot counter step
  } op_info_t;

  typedef struct packed {
    logic [ShapeBits-1:0] texture_shape;
    logic [AddrBits-1:0]  texture_address;
    logic [OffBits-1:0]   list_offset;
    logic [VtxBits-1:0]   vertex_c;
    logic [VtxBits-1:0]   vertex_b;
    logic [VtxBits-1:0]   vertex_a;
  } result_t;

  function automatic logic is_group(input logic [7:0] op);
    return op >= OpGroupLo && op <= OpGroupHi;
  endfunction

  function automatic logic is_tex(input logic [7:0] op);
    return op >= OpTexLo && op <= OpTexHi;
  endfunction

  function automatic op_info_t op_info(input logic [7:0] op);
    op_info_t r;
    r.known = 1'b1;
    r.len   = 3'd0;
    r.adv   = 3'd1;
    priority if (is_group(op) || op == OpTri || op == OpCall) begin
      r.len = 3'd2;
    end else if ((op >= OpPair3Lo && op <= OpPair3Hi) || op == OpPair3Alt) begin
      r.len = 3'd2;
      r.adv = 3'd3;
    end else if (op == OpVtx || op == OpQuad) begin
      r.len = 3'd4;
    end else if (is_tex(op)) begin
      r.len = 3'd3;
      r.adv = 3'd5;
    end else if (op == OpSkip3) begin
      r.len = 3'd3;
    end else if (op <= OpWideHi) begin
      r.adv = 3'd3;
    end else if (op <= OpShortHi || op == OpEnd || op == OpTexOn || op == OpTexOff
                 || (op >= OpNopLo && op <= OpNopHi)
                 || (op >= OpNop2Lo && op <= OpNop2Hi)) begin
      r.adv = 3'd1;
    end else begin
      r.known = 1'b0;
    end
    return r;
  endfunction

  // (op - 0x20) mod 3 over the texture load range
  function automatic logic [ShapeBits-1:0] tex_shape(input logic [2:0] sub);
    logic [ShapeBits-1:0] s;
    unique case (sub)
      3'd0, 3'd3: s = 2'd0;
      3'd1, 3'd4: s = 2'd1;
      3'd2, 3'd5: s = 2'd2;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

@@ src/packed_display_list_parser.sv @@
// Decodes a packed display list arriving one byte per request on the input
// stream and emits at most one event per byte on the output stream. Throughput
// is one byte per clock while the output is not stalled; each byte passes the
// input register, then the decode stage that holds the parser state and loads
// the result register. tuser on the input marks the first byte of a list, which
// clears the slot counter, the halt flag and any partial command. After a
// terminator or an unknown opcode all bytes are dropped until the next list
// start. Bytes that produce no event are consumed silently.
module packed_display_list_parser
  import pdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // list byte
  input  logic                 s_axis_tuser,  // list_start
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // vertex_a, vertex_b, vertex_c, list_offset, texture_address, texture_shape
  output logic [TdataBits-1:0] m_axis_tdata,
  output logic [KindBits-1:0]  m_axis_tuser   // kind
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_start;
  logic               out_valid;
  result_t            out_res;
  logic [KindBits-1:0] out_kind;

  logic [7:0]         cur_op, cur_op_next;
  logic [2:0]         payload_left, payload_left_next;
  logic [7:0]         held_low, held_low_next;
  logic [VtxBits-1:0] vertex_base, vertex_base_next;
  logic [CntBits-1:0] slot_counter, slot_counter_next;
  logic               halted, halted_next;

  logic               out_room, fire, emit;
  result_t            res;
  logic [KindBits-1:0] res_kind;

  logic [2:0]         left_eff, idx;
  logic               halt_eff;
  logic [CntBits-1:0] cnt_eff, cnt_adv;
  op_info_t           new_info, cur_info;
  logic [15:0]        hw;

  assign out_room      = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_room;
  assign s_axis_tready = !in_valid || out_room;

  assign left_eff = in_start ? 3'd0 : payload_left;
  assign halt_eff = in_start ? 1'b0 : halted;
  assign cnt_eff  = in_start ? '0 : slot_counter;
  assign new_info = op_info(in_byte);
  assign cur_info = op_info(cur_op);
  assign cnt_adv  = cnt_eff + CntBits'(new_info.adv);
  assign idx      = cur_info.len - left_eff;
  assign hw       = {in_byte, held_low};

  always_comb begin
    cur_op_next       = cur_op;
    payload_left_next = left_eff;
    held_low_next     = held_low;
    vertex_base_next  = vertex_base;
    slot_counter_next = cnt_eff;
    halted_next       = halt_eff;
    emit              = 1'b0;
    res_kind          = KindBad;
    res               = '0;
    priority if (halt_eff) begin
      emit = 1'b0;
    end else if (left_eff == 3'd0) begin
      priority if (in_byte == OpTerm) begin
        halted_next = 1'b1;
        emit        = 1'b1;
        res_kind    = KindTerm;
      end else if (!new_info.known) begin
        halted_next = 1'b1;
        emit        = 1'b1;
        res_kind    = KindBad;
      end else begin
        cur_op_next       = in_byte;
        payload_left_next = new_info.len;
        slot_counter_next = cnt_adv;
        priority if (in_byte == OpEnd) begin
          emit            = 1'b1;
          res_kind        = KindEnd;
          res.list_offset = OffBits'({cnt_adv, 3'b000});
        end else if (in_byte == OpTexOn) begin
          emit     = 1'b1;
          res_kind = KindTexOn;
        end else if (in_byte == OpTexOff) begin
          emit     = 1'b1;
          res_kind = KindTexOff;
        end else begin
          emit = 1'b0;
        end
      end
    end else begin
      payload_left_next = left_eff - 3'd1;
      priority if (is_tex(cur_op)) begin
        if (idx == 3'd0) begin
          emit                = 1'b1;
          res_kind            = KindTex;
          res.texture_address = AddrBits'({in_byte, 11'b0});
          res.texture_shape   = tex_shape(cur_op[2:0]);
        end
      end else if (is_group(cur_op) || cur_op == OpVtx || cur_op == OpTri
                   || cur_op == OpQuad || cur_op == OpCall) begin
        priority if (!idx[0]) begin
          held_low_next = in_byte;
        end else if (is_group(cur_op) || (cur_op == OpVtx && idx == 3'd1)) begin
          vertex_base_next = hw + 16'd1;
          emit             = 1'b1;
          res_kind         = is_group(cur_op) ? KindVtxGroup : KindVtx;
          res.vertex_a     = hw + 16'd1;
        end else if (cur_op == OpCall) begin
          emit            = 1'b1;
          res_kind        = KindCall;
          res.list_offset = OffBits'({hw, 3'b000});
        end else if (cur_op == OpTri || cur_op == OpQuad) begin
          emit         = 1'b1;
          res_kind     = KindTri;
          res.vertex_a = VtxBits'(hw[4:0]) + vertex_base;
          res.vertex_b = VtxBits'(hw[9:5]) + vertex_base;
          res.vertex_c = VtxBits'(hw[14:10]) + vertex_base;
        end else begin
          // second halfword of a plain vertex load carries nothing
          emit = 1'b0;
        end
      end else begin
        emit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_op       <= '0;
      payload_left <= '0;
      vertex_base  <= '0;
      slot_counter <= '0;
      halted       <= 1'b0;
    end else if (fire) begin
      cur_op       <= cur_op_next;
      payload_left <= payload_left_next;
      vertex_base  <= vertex_base_next;
      slot_counter <= slot_counter_next;
      halted       <= halted_next;
    end
    if (fire) begin
      held_low <= held_low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= fire && emit;
    end
    if (fire && emit) begin
      out_res  <= res;
      out_kind <= res_kind;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TdataBits'(out_res);
  assign m_axis_tuser  = out_kind;

endmodule

@@ src/pdlp_checker.sv @@
module pdlp_checker
  import pdlp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TdataBits-1:0] m_axis_tdata,
  input logic [KindBits-1:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_tri_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KindTri |-> m_axis_tdata[95:48] == '0)
    else $error("triangle carries offset or texture bits");

  a_load_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KindVtxGroup || m_axis_tuser == KindVtx)
      |-> m_axis_tdata[95:16] == '0)
    else $error("vertex load carries extra fields");

  a_tex_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KindTex
      |-> m_axis_tdata[81:0] == '0 && m_axis_tdata[91:90] != 2'd3)
    else $error("texture load fields malformed");

endmodule

bind packed_display_list_parser pdlp_checker u_pdlp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
